// File: hw/rtl/b64sd_pkg.sv
// Package with the shared codes, types and the character lookup of the base64 decoder.
`default_nettype none

package b64sd_pkg;

  // Width of the character, byte, sextet and accumulator paths.
  localparam int unsigned CharW = 8;
  localparam int unsigned ByteW = 8;
  localparam int unsigned SextW = 6;
  localparam int unsigned AccW  = 24;
  localparam int unsigned PhW   = 3;
  localparam int unsigned StW   = 3;

  // Largest number of result items that one input item causes.
  localparam int unsigned MaxRes = 3;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  // The padding character.
  localparam logic [CharW-1:0] PadChar = 8'h3D;

  // Lookup codes for characters that carry no sextet.
  localparam logic [CharW-1:0] SextInvalid = 8'hFF;
  localparam logic [CharW-1:0] SextSkip    = 8'hFE;

  // Phase codes: zero to three sextets collected, after one pad, group closed.
  localparam logic [PhW-1:0] PhS0   = 3'd0;
  localparam logic [PhW-1:0] PhS1   = 3'd1;
  localparam logic [PhW-1:0] PhS2   = 3'd2;
  localparam logic [PhW-1:0] PhS3   = 3'd3;
  localparam logic [PhW-1:0] PhPad1 = 3'd4;
  localparam logic [PhW-1:0] PhDone = 3'd5;

  // Status codes of a result item.
  typedef enum logic [StW-1:0] {
    StOk       = 3'd0,
    StEnd      = 3'd1,
    StPad      = 3'd2,
    StInvalid  = 3'd3,
    StAfterPad = 3'd4
  } status_e;

  // One group of result items waiting for the output side.
  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
    logic [ByteW-1:0] byte2;
    status_e          status;
  } grp_t;

  // Maps a character to its sextet value, or to the skip or invalid code.
  function automatic logic [CharW-1:0] sextet_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    begin
      v = SextInvalid;
      if (c >= 8'h41 && c <= 8'h5A) begin
        v = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        v = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
        v = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
        v = 8'd62;
      end else if (c == 8'h2F) begin
        v = 8'd63;
      end else if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
                   c == 8'h0B || c == 8'h0C) begin
        v = SextSkip;
      end
      return v;
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/base64_stream_decoder_unit.sv
// Top level of the streaming base64 decoder: one character per item in, decoded bytes out.
//
// The decoder takes one base64 character, or an end-of-data mark, per input item and
// returns up to three result items (decoded byte, last flag, status) for it. An accepted
// item waits in an input register until the group is free, is decoded against the
// accumulator and phase in one pass, and its results are loaded into a group register
// that the output side drains one item per cycle unless out_stall_i is set. Items that
// cause no result, or one, likewise flow at one per cycle. An item that causes two or
// three results holds the output port until its last result leaves and stalls the input
// meanwhile, so the rate is bounded by the single-item output port at one result per
// cycle. Errors give one result with a nonzero status and a zero byte; the state then clears.
`default_nettype none

module base64_stream_decoder_unit
  import b64sd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Input channel.
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CharW-1:0] char_in_i,
  input  wire logic             end_of_data_i,
  // Output channel.
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ByteW-1:0]      data_byte_o,
  output logic                  last_o,
  output logic [StW-1:0]        status_o
);

  // Input register.
  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  logic             eod_q;

  // Decoder state.
  logic [AccW-1:0]  acc_q, acc_d;
  logic [PhW-1:0]   phase_q, phase_d;

  // Result group register and its read position.
  logic             grp_valid_q, grp_valid_d;
  grp_t             grp_q;
  grp_t             grp_d;
  logic [CntW-1:0]  idx_q, idx_d;

  // Handshake terms.
  logic             in_fire;
  logic             out_fire;
  logic             grp_last;
  logic             grp_free;
  logic             proc;

  // Decoder lookup and new accumulator.
  logic [CharW-1:0] sext;
  logic [AccW-1:0]  acc_shift;

  // The group is free when empty or when its last item leaves this cycle.
  assign grp_last   = (idx_q == grp_q.count - CntW'(1));
  assign out_fire   = grp_valid_q && !out_stall_i;
  assign grp_free   = !grp_valid_q || (out_fire && grp_last);
  assign proc       = in_valid_q && grp_free;
  assign in_stall_o = in_valid_q && !grp_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign sext      = sextet_of(char_q);
  assign acc_shift = {acc_q[AccW-SextW-1:0], sext[SextW-1:0]};

  // Decode one item against the current phase.
  always_comb begin
    acc_d   = acc_q;
    phase_d = phase_q;
    grp_d   = '{count: '0, byte0: '0, byte1: '0, byte2: '0, status: StOk};
    if (eod_q) begin
      // End of data closes an open group.
      case (phase_q)
        PhS1: begin
          grp_d.count  = CntW'(1);
          grp_d.status = StEnd;
          acc_d        = '0;
          phase_d      = PhS0;
        end
        PhS2: begin
          grp_d.count = CntW'(1);
          grp_d.byte0 = acc_q[11:4];
          phase_d     = PhDone;
        end
        PhS3: begin
          grp_d.count = CntW'(2);
          grp_d.byte0 = acc_q[17:10];
          grp_d.byte1 = acc_q[9:2];
          phase_d     = PhDone;
        end
        default: begin
        end
      endcase
    end else if (sext == SextSkip) begin
      // Whitespace leaves everything unchanged.
    end else if (sext == SextInvalid) begin
      if (char_q != PadChar) begin
        grp_d.count  = CntW'(1);
        grp_d.status = StInvalid;
        acc_d        = '0;
        phase_d      = PhS0;
      end else begin
        // Padding character.
        case (phase_q)
          PhS1: begin
            grp_d.count  = CntW'(1);
            grp_d.status = StEnd;
            acc_d        = '0;
            phase_d      = PhS0;
          end
          PhS2: begin
            grp_d.count = CntW'(1);
            grp_d.byte0 = acc_q[11:4];
            phase_d     = PhPad1;
          end
          PhS3: begin
            grp_d.count = CntW'(2);
            grp_d.byte0 = acc_q[17:10];
            grp_d.byte1 = acc_q[9:2];
            phase_d     = PhDone;
          end
          PhPad1: begin
            phase_d = PhDone;
          end
          default: begin
            grp_d.count  = CntW'(1);
            grp_d.status = StPad;
            acc_d        = '0;
            phase_d      = PhS0;
          end
        endcase
      end
    end else if (phase_q > PhS3) begin
      // Alphabet character after the group was padded or closed.
      grp_d.count  = CntW'(1);
      grp_d.status = StAfterPad;
      acc_d        = '0;
      phase_d      = PhS0;
    end else if (phase_q == PhS3) begin
      // Fourth sextet completes a group of three bytes.
      grp_d.count = CntW'(3);
      grp_d.byte0 = acc_shift[23:16];
      grp_d.byte1 = acc_shift[15:8];
      grp_d.byte2 = acc_shift[7:0];
      acc_d       = '0;
      phase_d     = PhS0;
    end else begin
      acc_d   = acc_shift;
      phase_d = phase_q + PhW'(1);
    end
  end

  // Group valid and read position.
  always_comb begin
    grp_valid_d = grp_valid_q;
    idx_d       = idx_q;
    if (proc && grp_d.count != '0) begin
      grp_valid_d = 1'b1;
      idx_d       = '0;
    end else if (out_fire && grp_last) begin
      grp_valid_d = 1'b0;
      idx_d       = '0;
    end else if (out_fire) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      acc_q       <= '0;
      phase_q     <= PhS0;
      grp_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        acc_q   <= acc_d;
        phase_q <= phase_d;
      end
      grp_valid_q <= grp_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= char_in_i;
      eod_q  <= end_of_data_i;
    end
    if (proc && grp_d.count != '0) begin
      grp_q <= grp_d;
    end
  end

  // Output item selection.
  always_comb begin
    case (idx_q)
      CntW'(0): data_byte_o = grp_q.byte0;
      CntW'(1): data_byte_o = grp_q.byte1;
      default:  data_byte_o = grp_q.byte2;
    endcase
  end

  assign out_valid_o = grp_valid_q;
  assign last_o      = grp_last;
  assign status_o    = grp_q.status;

  // The read position stays inside the loaded group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (idx_q < grp_q.count))
    else $error("read position past end of result group");

  // An error result is a single item with a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> (data_byte_o == '0 && last_o))
    else $error("error result is not a single zero item");

  // The phase never takes an unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhDone)
    else $error("phase holds an unused code");

  // Input is only held back while an item waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && grp_valid_q))
    else $error("input stalled with nothing pending");

  // An error clears the decoder state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && grp_d.status != StOk) |=> (acc_q == '0 && phase_q == PhS0))
    else $error("state not cleared after error");

endmodule

`default_nettype wire
